FILE: rtl/core/bone_vertex_rotate_translate_core_macros.svh
// Assertion macros for the bone vertex core
`ifndef BONE_VERTEX_ROTATE_TRANSLATE_CORE_MACROS_SVH
`define BONE_VERTEX_ROTATE_TRANSLATE_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define BVR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication with the consequent checked in the next cycle
`define BVR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/bvr_pkg.sv
// ----------------------------------------------------------------------------
// bvr_pkg
// Shared types and constants for the bone vertex rotate/translate core.
// ----------------------------------------------------------------------------
package bvr_pkg;
    localparam int unsigned MAX_BONES_DEF = 128;
    localparam int unsigned BONE_W        = 7;
    localparam int unsigned SEL_W         = 4;
    localparam int unsigned CRD_W         = 32;
    localparam int unsigned TRIG_W        = 16;
    localparam int unsigned FRAC_SH       = 14;
    localparam int unsigned S_TDATA_W     = 144;
    localparam int unsigned M_TDATA_W     = 96;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_XFRM = 1'b1;

    localparam logic [SEL_W-1:0] SEL_PIV_X = 4'd0;
    localparam logic [SEL_W-1:0] SEL_PIV_Z = 4'd2;
    localparam logic [SEL_W-1:0] SEL_COS_A = 4'd3;
    localparam logic [SEL_W-1:0] SEL_SIN_C = 4'd8;
    localparam logic [SEL_W-1:0] SEL_NOD_X = 4'd9;
    localparam logic [SEL_W-1:0] SEL_NOD_Z = 4'd11;

    // one transform item, as it leaves the front
    typedef struct packed {
        logic               in_range;
        logic [CRD_W-1:0]   vx;
        logic [CRD_W-1:0]   vy;
        logic [CRD_W-1:0]   vz;
        logic               last;
    } bvr_job_t;

    // table write from the front
    typedef struct packed {
        logic                en;
        logic [1:0]          bank;   // 0 pivot, 1 rotation, 2 node
        logic [3:0]          word;
        logic [CRD_W-1:0]    value;
    } bvr_wr_t;

    localparam logic [1:0] BANK_PIV = 2'd0;
    localparam logic [1:0] BANK_ROT = 2'd1;
    localparam logic [1:0] BANK_NOD = 2'd2;

    function automatic logic signed [CRD_W-1:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi) return {1'b0, {(CRD_W-1){1'b1}}};
        else if (v < lo) return {1'b1, {(CRD_W-1){1'b0}}};
        else return v[CRD_W-1:0];
    endfunction
endpackage

FILE: rtl/core/bvr_ram.sv
// ----------------------------------------------------------------------------
// bvr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bvr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/core/bvr_front.sv
// ----------------------------------------------------------------------------
// bvr_front
// Accepts input beats, decodes table writes and queues transform jobs.
// ----------------------------------------------------------------------------
module bvr_front #(
    parameter int unsigned MAX_BONES = bvr_pkg::MAX_BONES_DEF,
    parameter int unsigned Q_DEPTH   = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bvr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output bvr_pkg::bvr_wr_t              wr,
    output logic [bvr_pkg::BONE_W-1:0]    wr_bone,
    output logic                          job_valid,
    input  logic                          job_ready,
    output bvr_pkg::bvr_job_t             job,
    output logic [bvr_pkg::BONE_W-1:0]    job_bone
);
    import bvr_pkg::*;

    localparam int unsigned PW = $clog2(Q_DEPTH);
    localparam int unsigned JW = $bits(bvr_job_t) + BONE_W;

    logic [BONE_W-1:0]      bone;
    logic [SEL_W-1:0]       sel;
    logic [CRD_W-1:0]       val;
    logic                   in_rng;
    logic                   acc;
    logic                   load_ok;
    logic [JW-1:0]          q_mem [Q_DEPTH];
    logic [PW-1:0]          wp_reg, rp_reg;
    logic [PW:0]            cnt_reg, cnt_next;
    logic                   push, pop;
    bvr_job_t               nj;

    assign bone   = s_tdata[BONE_W-1:0];
    assign sel    = s_tdata[BONE_W +: SEL_W];
    assign val    = s_tdata[BONE_W+SEL_W +: CRD_W];
    assign in_rng = ({25'd0, bone} < MAX_BONES);

    // a load writes the table at its accept edge, so it waits until every
    // queued transform has issued its table read (same-edge read sees old data)
    assign load_ok  = (cnt_reg == '0) || ((cnt_reg == {{PW{1'b0}}, 1'b1}) && pop);
    assign s_tready = (s_tuser == OP_XFRM) ? (cnt_reg != Q_DEPTH[PW:0]) : load_ok;
    assign acc      = s_tvalid && s_tready;
    assign push     = acc && (s_tuser == OP_XFRM);
    assign pop      = job_valid && job_ready;

    always_comb begin
        wr       = '0;
        wr.value = val;
        wr_bone  = bone;
        if (acc && s_tuser == OP_LOAD && in_rng) begin
            if (sel <= SEL_PIV_Z) begin
                wr.en   = 1'b1;
                wr.bank = BANK_PIV;
                wr.word = sel - SEL_PIV_X;
            end else if (sel <= SEL_SIN_C) begin
                wr.en   = 1'b1;
                wr.bank = BANK_ROT;
                wr.word = sel - SEL_COS_A;
            end else if (sel <= SEL_NOD_Z) begin
                wr.en   = 1'b1;
                wr.bank = BANK_NOD;
                wr.word = sel - SEL_NOD_X;
            end
        end
    end

    always_comb begin
        nj.in_range = in_rng;
        nj.vx       = s_tdata[43 +: CRD_W];
        nj.vy       = s_tdata[75 +: CRD_W];
        nj.vz       = s_tdata[107 +: CRD_W];
        nj.last     = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= {nj, bone};
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= (wp_reg == PW'(Q_DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == PW'(Q_DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
    end

    assign job_valid = (cnt_reg != '0);
    assign {job, job_bone} = q_mem[rp_reg];
endmodule

FILE: rtl/core/bvr_back.sv
// ----------------------------------------------------------------------------
// bvr_back
// Bone table and the pivot/rotate/translate pipeline with output skid.
// ----------------------------------------------------------------------------
module bvr_back #(
    parameter int unsigned MAX_BONES = bvr_pkg::MAX_BONES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bvr_pkg::bvr_wr_t              wr,
    input  logic [bvr_pkg::BONE_W-1:0]    wr_bone,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  bvr_pkg::bvr_job_t             job,
    input  logic [bvr_pkg::BONE_W-1:0]    job_bone,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bvr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import bvr_pkg::*;
    `include "bone_vertex_rotate_translate_core_macros.svh"

    // bone index field limits the table; keep at least two rows
    localparam int unsigned RD = (MAX_BONES >= (2 ** BONE_W)) ? (2 ** BONE_W) :
                                 ((MAX_BONES > 1) ? MAX_BONES : 2);
    localparam int unsigned AW = $clog2(RD);
    localparam int unsigned NS = 8;     // pipeline stages
    localparam int unsigned OD = NS + 2; // output FIFO covers all in flight
    localparam int unsigned OW = $clog2(OD);

    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic signed [TRIG_W-1:0] trg_t;
    typedef logic signed [47:0] prd_t;

    // ---------------- table RAMs: one per word ----------------
    logic [CRD_W-1:0]  piv_q [3];
    logic [CRD_W-1:0]  nod_q [3];
    logic [TRIG_W-1:0] rot_q [6];
    logic [AW-1:0]     waddr, raddr;
    logic              adv;

    assign waddr = wr_bone[AW-1:0];
    assign raddr = job_bone[AW-1:0];

    for (genvar g = 0; g < 3; g++) begin : g_pos
        bvr_ram #(.WIDTH(CRD_W), .DEPTH(RD)) u_piv (
            .aclk(aclk), .we(wr.en && wr.bank == BANK_PIV && wr.word == 4'(g)),
            .waddr(waddr), .wdata(wr.value), .re(adv), .raddr(raddr),
            .rdata(piv_q[g]));
        bvr_ram #(.WIDTH(CRD_W), .DEPTH(RD)) u_nod (
            .aclk(aclk), .we(wr.en && wr.bank == BANK_NOD && wr.word == 4'(g)),
            .waddr(waddr), .wdata(wr.value), .re(adv), .raddr(raddr),
            .rdata(nod_q[g]));
    end
    for (genvar g = 0; g < 6; g++) begin : g_rot
        bvr_ram #(.WIDTH(TRIG_W), .DEPTH(RD)) u_rot (
            .aclk(aclk), .we(wr.en && wr.bank == BANK_ROT && wr.word == 4'(g)),
            .waddr(waddr), .wdata(wr.value[TRIG_W-1:0]), .re(adv), .raddr(raddr),
            .rdata(rot_q[g]));
    end

    // ---------------- output FIFO and credit ----------------
    logic [M_TDATA_W:0] of_mem [OD];
    logic [OW-1:0]      of_wp_reg, of_rp_reg;
    logic [OW:0]        of_cnt_reg;
    logic [OW:0]        infl_reg, infl_next;   // in pipe + in FIFO
    logic               of_push, of_pop;
    logic [NS-1:0]      vld_reg;

    assign job_ready = (infl_reg < OD[OW:0]);
    assign adv       = job_valid && job_ready;
    assign of_push   = vld_reg[NS-1];
    assign of_pop    = m_tvalid && m_tready;
    assign m_tvalid  = (of_cnt_reg != '0);
    assign {m_tlast, m_tdata} = of_mem[of_rp_reg];

    always_comb begin
        infl_next = infl_reg;
        if (adv && !of_pop) infl_next = infl_reg + 1'b1;
        else if (of_pop && !adv) infl_next = infl_reg - 1'b1;
    end

    // ---------------- datapath ----------------
    // s1: RAM read;  s2: subtract pivot;  s3/s4: pair A mult/sum;
    // s5/s6: pair B;  s7: pair C mult;  s8: pair C sum + node add
    bvr_job_t j1_reg;
    crd_t     nd2_reg [3], nd3_reg [3], nd4_reg [3], nd5_reg [3], nd6_reg [3], nd7_reg [3];
    trg_t     t2_reg [6], t3_reg [6], t4_reg [6], t5_reg [6], t6_reg [6];
    logic     l_reg [2:NS];
    crd_t     x2_reg, y2_reg, z2_reg;
    prd_t     a3_reg [4];
    crd_t     x3_reg, x4_reg, z4_reg, y4_reg;
    prd_t     b5_reg [4];
    crd_t     z5_reg, y6_reg, x6_reg, z6_reg;
    prd_t     c7_reg [4];
    crd_t     y7_reg, ox_reg, oy_reg, oz_reg;

    function automatic prd_t fl(input prd_t p);
        return p >>> FRAC_SH;
    endfunction

    function automatic crd_t rd(input logic [CRD_W-1:0] v, input logic ok);
        return ok ? crd_t'(v) : crd_t'(0);
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) j1_reg <= job;
        // stage 2
        x2_reg <= sat32(50'(signed'(j1_reg.vx)) - 50'(rd(piv_q[0], j1_reg.in_range)));
        y2_reg <= sat32(50'(signed'(j1_reg.vy)) - 50'(rd(piv_q[1], j1_reg.in_range)));
        z2_reg <= sat32(50'(signed'(j1_reg.vz)) - 50'(rd(piv_q[2], j1_reg.in_range)));
        for (int i = 0; i < 3; i++) nd2_reg[i] <= rd(nod_q[i], j1_reg.in_range);
        for (int i = 0; i < 6; i++)
            t2_reg[i] <= j1_reg.in_range ? trg_t'(rot_q[i]) : trg_t'(0);
        l_reg[2] <= j1_reg.last;
        // stage 3: pair A on (z,y)
        a3_reg[0] <= prd_t'(z2_reg) * prd_t'(t2_reg[0]);
        a3_reg[1] <= prd_t'(y2_reg) * prd_t'(t2_reg[1]);
        a3_reg[2] <= prd_t'(z2_reg) * prd_t'(t2_reg[1]);
        a3_reg[3] <= prd_t'(y2_reg) * prd_t'(t2_reg[0]);
        x3_reg <= x2_reg;
        // stage 4
        z4_reg <= sat32(50'(fl(a3_reg[0])) - 50'(fl(a3_reg[1])));
        y4_reg <= sat32(50'(fl(a3_reg[2])) + 50'(fl(a3_reg[3])));
        x4_reg <= x3_reg;
        // stage 5: pair B on (y,x)
        b5_reg[0] <= prd_t'(y4_reg) * prd_t'(t4_reg[2]);
        b5_reg[1] <= prd_t'(x4_reg) * prd_t'(t4_reg[3]);
        b5_reg[2] <= prd_t'(y4_reg) * prd_t'(t4_reg[3]);
        b5_reg[3] <= prd_t'(x4_reg) * prd_t'(t4_reg[2]);
        z5_reg <= z4_reg;
        // stage 6
        y6_reg <= sat32(50'(fl(b5_reg[0])) - 50'(fl(b5_reg[1])));
        x6_reg <= sat32(50'(fl(b5_reg[2])) + 50'(fl(b5_reg[3])));
        z6_reg <= z5_reg;
        // stage 7: pair C on (x,z)
        c7_reg[0] <= prd_t'(x6_reg) * prd_t'(t6_reg[4]);
        c7_reg[1] <= prd_t'(z6_reg) * prd_t'(t6_reg[5]);
        c7_reg[2] <= prd_t'(x6_reg) * prd_t'(t6_reg[5]);
        c7_reg[3] <= prd_t'(z6_reg) * prd_t'(t6_reg[4]);
        y7_reg <= y6_reg;
        // stage 8: sum pair C then add node
        ox_reg <= sat32(50'(sat32(50'(fl(c7_reg[0])) - 50'(fl(c7_reg[1]))))
                        + 50'(nd7_reg[0]));
        oy_reg <= sat32(50'(y7_reg) + 50'(nd7_reg[1]));
        oz_reg <= sat32(50'(sat32(50'(fl(c7_reg[2])) + 50'(fl(c7_reg[3]))))
                        + 50'(nd7_reg[2]));
        for (int i = 0; i < 3; i++) begin
            nd3_reg[i] <= nd2_reg[i];
            nd4_reg[i] <= nd3_reg[i];
            nd5_reg[i] <= nd4_reg[i];
            nd6_reg[i] <= nd5_reg[i];
            nd7_reg[i] <= nd6_reg[i];
        end
        for (int i = 0; i < 6; i++) begin
            t3_reg[i] <= t2_reg[i];
            t4_reg[i] <= t3_reg[i];
            t5_reg[i] <= t4_reg[i];
            t6_reg[i] <= t5_reg[i];
        end
        for (int k = 3; k <= NS; k++) l_reg[k] <= l_reg[k-1];
        if (of_push) of_mem[of_wp_reg] <= {l_reg[NS], oz_reg, oy_reg, ox_reg};
    end

    // stage NS result lands in ox/oy/oz; vld_reg[NS-1] marks it ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            infl_reg   <= '0;
            of_wp_reg  <= '0;
            of_rp_reg  <= '0;
            of_cnt_reg <= '0;
        end else begin
            vld_reg  <= {vld_reg[NS-2:0], adv};
            infl_reg <= infl_next;
            if (of_push) of_wp_reg <= (of_wp_reg == OW'(OD-1)) ? '0 : of_wp_reg + 1'b1;
            if (of_pop)  of_rp_reg <= (of_rp_reg == OW'(OD-1)) ? '0 : of_rp_reg + 1'b1;
            if (of_push && !of_pop) of_cnt_reg <= of_cnt_reg + 1'b1;
            else if (of_pop && !of_push) of_cnt_reg <= of_cnt_reg - 1'b1;
        end
    end

    `BVR_ASSERT_IMP(a_fifo_room, aclk, aresetn, of_push, (of_cnt_reg < OD[OW:0]) || of_pop, "output fifo overflow")
    `BVR_ASSERT_IMP(a_credit, aclk, aresetn, 1'b1, infl_reg <= OD[OW:0], "credit over limit")
    `BVR_ASSERT_IMP(a_cnt_le, aclk, aresetn, 1'b1, of_cnt_reg <= infl_reg, "fifo count above in-flight")
    `BVR_ASSERT_NEXT(a_adv_vld, aclk, aresetn, adv, vld_reg[0], "issued job not tracked")
endmodule

FILE: rtl/core/bone_vertex_rotate_translate_core.sv
// Path: an accepted transform beat goes through a job queue slot, the 8-stage
//   pipe and the output FIFO before it raises m_tvalid.
// Throughput: one beat per cycle sustained while m_tready stays high; a load beat
//   waits until every transform queued ahead of it has read the bone table.
// Reset (aresetn low, synchronous) empties the job queue, pipe and output FIFO;
//   bone table contents are kept and are undefined until written.
// ----------------------------------------------------------------------------
// bone_vertex_rotate_translate_core
// Skeletal vertex transform: pivot subtract, three Euler pair rotations,
// node translate, with saturating Q16.16 arithmetic.
// ----------------------------------------------------------------------------
module bone_vertex_rotate_translate_core #(
    parameter int unsigned MAX_BONES = bvr_pkg::MAX_BONES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // bone_index[6:0], word_select[10:7], word_value[42:11],
    // vert_x[74:43], vert_y[106:75], vert_z[138:107], zero pad [143:139]
    input  logic [bvr_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [bvr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import bvr_pkg::*;
    // front decodes table loads and queues transforms; back owns the table
    bvr_wr_t           wr;
    logic [BONE_W-1:0] wr_bone;
    logic              job_valid, job_ready;
    bvr_job_t          job;
    logic [BONE_W-1:0] job_bone;

    bvr_front #(.MAX_BONES(MAX_BONES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .wr(wr), .wr_bone(wr_bone),
        .job_valid(job_valid), .job_ready(job_ready), .job(job), .job_bone(job_bone)
    );

    bvr_back #(.MAX_BONES(MAX_BONES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .wr(wr), .wr_bone(wr_bone),
        .job_valid(job_valid), .job_ready(job_ready), .job(job), .job_bone(job_bone),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

FILE: test/tb_bone_vertex_rotate_translate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bone_vertex_rotate_translate_core
// Streams bone table loads and vertex transforms into the core, predicts each
// animated vertex from a local copy of the bone table and compares every
// output beat in order, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_bone_vertex_rotate_translate_core;
    import bvr_pkg::*;

    localparam int NBONES     = MAX_BONES_DEF;
    localparam int CYCLE_MAX  = 600000;
    localparam int RAND_ITEMS = 1500;
    localparam int RAND_BONES = 32;
    localparam int QUIET_TAIL = 200;

    localparam logic [SEL_W-1:0] SEL_PIV_Y = 4'd1;
    localparam logic [SEL_W-1:0] SEL_NOD_Y = 4'd10;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    bone_vertex_rotate_translate_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // one expected output beat
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        done;
    } vtx_out_t;

    // local copy of the bone table
    logic [31:0] pivot_tbl [NBONES][3];
    logic [15:0] trig_tbl  [NBONES][6];
    logic [31:0] node_tbl  [NBONES][3];
    logic [11:0] word_seen [NBONES];    // which words of each bone were loaded

    vtx_out_t vtx_pending[$];
    int       errors;
    int       cycles;
    bit       quiet;                    // no idling on either side

    // edge samples, taken at the falling edge when everything is settled
    logic                 sv_s_valid, sv_s_ready, sv_s_user, sv_s_last;
    logic [S_TDATA_W-1:0] sv_s_data;
    logic                 sv_m_valid, sv_m_ready, sv_m_last;
    logic [M_TDATA_W-1:0] sv_m_data;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(negedge aclk) begin
        sv_s_valid <= s_tvalid;
        sv_s_ready <= s_tready;
        sv_s_user  <= s_tuser;
        sv_s_last  <= s_tlast;
        sv_s_data  <= s_tdata;
        sv_m_valid <= m_tvalid;
        sv_m_ready <= m_tready;
        sv_m_last  <= m_tlast;
        sv_m_data  <= m_tdata;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 times Q2.14, floored back to Q16.16
    function automatic longint fxmul(input longint c, input longint t);
        longint p;
        p = c * t;
        return p >>> 14;
    endfunction

    function automatic vtx_out_t skin_vertex(input logic [6:0] bone,
            input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
            input logic last);
        longint   x, y, z, a, b, t[6];
        vtx_out_t r;
        for (int i = 0; i < 6; i++) t[i] = longint'($signed(trig_tbl[bone][i]));
        x = clamp32(longint'($signed(vx)) - longint'($signed(pivot_tbl[bone][0])));
        y = clamp32(longint'($signed(vy)) - longint'($signed(pivot_tbl[bone][1])));
        z = clamp32(longint'($signed(vz)) - longint'($signed(pivot_tbl[bone][2])));
        // pair A on (z,y)
        a = clamp32(fxmul(z, t[0]) - fxmul(y, t[1]));
        b = clamp32(fxmul(z, t[1]) + fxmul(y, t[0]));
        z = a; y = b;
        // pair B on (y,x)
        a = clamp32(fxmul(y, t[2]) - fxmul(x, t[3]));
        b = clamp32(fxmul(y, t[3]) + fxmul(x, t[2]));
        y = a; x = b;
        // pair C on (x,z)
        a = clamp32(fxmul(x, t[4]) - fxmul(z, t[5]));
        b = clamp32(fxmul(x, t[5]) + fxmul(z, t[4]));
        x = a; z = b;
        r.px   = 32'(clamp32(x + longint'($signed(node_tbl[bone][0]))));
        r.py   = 32'(clamp32(y + longint'($signed(node_tbl[bone][1]))));
        r.pz   = 32'(clamp32(z + longint'($signed(node_tbl[bone][2]))));
        r.done = last;
        return r;
    endfunction

    // every accepted input beat updates the table copy or queues a vertex
    always @(posedge aclk) begin
        logic [6:0]       bone;
        logic [SEL_W-1:0] sel;
        logic [31:0]      val;
        if (aresetn && sv_s_valid && sv_s_ready) begin
            bone = sv_s_data[6:0];
            sel  = sv_s_data[10:7];
            val  = sv_s_data[42:11];
            if (sv_s_user == OP_XFRM) begin
                vtx_pending.push_back(skin_vertex(bone, sv_s_data[74:43],
                    sv_s_data[106:75], sv_s_data[138:107], sv_s_last));
            end else if (sel <= SEL_PIV_Z) begin
                pivot_tbl[bone][sel] = val;
                word_seen[bone][sel] = 1'b1;
            end else if (sel <= SEL_SIN_C) begin
                trig_tbl[bone][sel - SEL_COS_A] = val[15:0];
                word_seen[bone][sel] = 1'b1;
            end else if (sel <= SEL_NOD_Z) begin
                node_tbl[bone][sel - SEL_NOD_X] = val;
                word_seen[bone][sel] = 1'b1;
            end
        end
    end

    // output checker
    always @(posedge aclk) begin
        vtx_out_t e;
        if (aresetn && sv_m_valid && sv_m_ready) begin
            if (vtx_pending.size() == 0) begin
                $display("%0t: unexpected beat x=%h y=%h z=%h last=%b", $time,
                         sv_m_data[31:0], sv_m_data[63:32], sv_m_data[95:64], sv_m_last);
                errors++;
            end else begin
                e = vtx_pending.pop_front();
                if (sv_m_data[31:0] !== e.px) begin
                    $display("%0t: out_x exp %h got %h", $time, e.px, sv_m_data[31:0]);
                    errors++;
                end
                if (sv_m_data[63:32] !== e.py) begin
                    $display("%0t: out_y exp %h got %h", $time, e.py, sv_m_data[63:32]);
                    errors++;
                end
                if (sv_m_data[95:64] !== e.pz) begin
                    $display("%0t: out_z exp %h got %h", $time, e.pz, sv_m_data[95:64]);
                    errors++;
                end
                if (sv_m_last !== e.done) begin
                    $display("%0t: mesh_done exp %b got %b", $time, e.done, sv_m_last);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure: random stall bursts
    always @(posedge aclk) begin
        int unsigned hold;
        if (!aresetn || quiet) begin
            m_tready <= 1'b1;
            hold = 0;
        end else if (hold != 0) begin
            hold--;
            if (hold == 0) m_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            hold = $urandom_range(1, 18);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_beat(input logic op, input logic [6:0] bone,
            input logic [SEL_W-1:0] sel, input logic [31:0] val,
            input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
            input logic last);
        logic [143:0] pk;
        int unsigned  gap;
        if (!quiet && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pk = {5'b0, vz, vy, vx, val, sel, bone};
        s_tvalid <= 1'b1;
        s_tdata  <= pk[S_TDATA_W-1:0];
        s_tuser  <= op;
        s_tlast  <= last;
        do @(posedge aclk); while (!(sv_s_valid && sv_s_ready));
    endtask

    task automatic load_word(input logic [6:0] bone, input logic [SEL_W-1:0] sel,
                             input logic [31:0] val);
        send_beat(OP_LOAD, bone, sel, val, $urandom, $urandom, $urandom,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic transform(input logic [6:0] bone, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz, input logic last);
        send_beat(OP_XFRM, bone, 4'($urandom), $urandom, vx, vy, vz, last);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
        endcase
    endfunction

    // trig word: low 16 bits hold Q2.14, upper bits are junk the core drops
    function automatic logic [31:0] rand_trig();
        logic [15:0] t;
        case ($urandom_range(0, 5))
            0: t = 16'h8000;
            1: t = 16'h7FFF;
            2: t = 16'($urandom);
            default: t = 16'($signed($urandom_range(0, 32768)) - 16'sd16384);
        endcase
        return {16'($urandom), t};
    endfunction

    task automatic load_bone(input logic [6:0] bone, input logic [31:0] w[12]);
        for (int i = 0; i < 12; i++) load_word(bone, 4'(i), w[i]);
    endtask

    task automatic load_random_bone(input logic [6:0] bone);
        logic [31:0] w[12];
        for (int i = 0; i < 12; i++)
            w[i] = (i >= SEL_COS_A && i <= SEL_SIN_C) ? rand_trig() : rand_coord();
        load_bone(bone, w);
    endtask

    task automatic wait_drained();
        while (vtx_pending.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_identity();
        logic [31:0] w[12] = '{0, 0, 0, 32'h4000, 0, 32'h4000, 0, 32'h4000, 0, 0, 0, 0};
        load_bone(7'd0, w);
        transform(7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
        transform(7'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // saturation on pivot subtract, rotation and node add
    task automatic test_saturation();
        logic [31:0] w[12] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h8000, 32'h7FFF, 32'h8000, 32'h8000, 32'h7FFF, 32'h7FFF,
                               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        load_bone(7'd127, w);
        transform(7'd127, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        transform(7'd127, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        transform(7'd127, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    endtask

    // unused selects and junk high bits on trig words change nothing
    task automatic test_ignored_fields();
        load_word(7'd0, 4'd12, $urandom);
        load_word(7'd0, 4'd13, $urandom);
        load_word(7'd0, 4'd14, $urandom);
        load_word(7'd0, 4'd15, 32'hFFFF_FFFF);
        load_word(7'd0, SEL_COS_A, 32'hABCD_4000);
        transform(7'd0, 32'h0003_8000, 32'hFFFE_0001, 32'h1234_5678, 1'b1);
        load_word(7'd0, SEL_PIV_Y, 32'h0000_8000);
        load_word(7'd0, SEL_NOD_Y, 32'hFFFF_0000);
        transform(7'd0, 32'h0003_8000, 32'hFFFE_0001, 32'h1234_5678, 1'b0);
    endtask

    task automatic test_random();
        logic [6:0] bone;
        for (int b = 1; b < 20; b++) load_random_bone(7'(b));
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
            bone = 7'($urandom_range(0, RAND_BONES - 1));
            if ($urandom_range(0, 19) == 0) begin
                load_word(bone, 4'($urandom_range(0, 15)),
                          $urandom_range(0, 1) ? rand_trig() : rand_coord());
            end else if (word_seen[bone] != 12'hFFF) begin
                load_random_bone(bone);
            end else begin
                transform(bone, rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 15) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    initial begin
        int waited;
        errors    = 0;
        cycles    = 0;
        quiet     = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        s_tlast   = 1'b0;
        m_tready  = 1'b1;
        for (int b = 0; b < NBONES; b++) word_seen[b] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_identity();
        test_saturation();
        test_ignored_fields();
        test_random();

        s_tvalid <= 1'b0;
        wait_drained();
        waited = 0;
        while (waited < 40) begin
            @(posedge aclk);
            waited++;
        end
        if (errors == 0 && vtx_pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
